>>> rtl/core/mf3_pkg.sv
// Shared types and helpers for the 3x3 median filter.
// Pixel, window and transaction types, and the compare-exchange functions.
// No dependencies.
`timescale 1ns / 1ps

package mf3_pkg;

   typedef logic [7:0] pixel_type;

   // Window indexed [row][column]; row 0 is the oldest line, column 2 the newest pixel.
   typedef pixel_type [2:0][2:0] window_type;

   typedef struct packed {
      logic      req_type;
      pixel_type in_pixel;
   } req_item_type;

   typedef struct packed {
      pixel_type out_pixel;
      logic      frame_last;
   } rsp_item_type;

   typedef struct packed {
      logic valid;
      logic last;
   } tag_type;

   typedef struct packed {
      pixel_type lo;
      pixel_type mid;
      pixel_type hi;
   } trio_type;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   localparam logic [11:0] FRAME_WIDTH_RESET  = 12'd640;
   localparam logic [11:0] FRAME_HEIGHT_RESET = 12'd480;
   localparam logic [11:0] MIN_WIDTH          = 12'd3;
   localparam logic       REQ_FLUSH           = 1'b1;

   function automatic trio_type sort3(input pixel_type a, input pixel_type b,
                                      input pixel_type c);
      pixel_type lo_ab;
      pixel_type hi_ab;
      trio_type  res;
      lo_ab   = (a < b) ? a : b;
      hi_ab   = (a < b) ? b : a;
      res.lo  = (lo_ab < c) ? lo_ab : c;
      res.hi  = (hi_ab > c) ? hi_ab : c;
      res.mid = (lo_ab > ((hi_ab < c) ? hi_ab : c)) ? lo_ab : ((hi_ab < c) ? hi_ab : c);
      return res;
   endfunction

endpackage

>>> rtl/core/mf3_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module mf3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/mf3_median.sv
// Two-stage median-of-nine network: sort the columns, then combine the column
// extremes and middles. Depends on mf3_pkg.
`timescale 1ns / 1ps

module mf3_median
   import mf3_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       enable,
   input  tag_type    in_tag,
   input  window_type in_win,
   output tag_type    out_tag,
   output pixel_type  out_pixel
);

   trio_type [2:0] col_in;
   trio_type [2:0] col_ff;
   tag_type        tag_a_ff;
   trio_type       comb_in;
   trio_type       comb_ff;
   tag_type        tag_b_ff;
   trio_type       final_sort;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         col_in[c] = sort3(in_win[0][c], in_win[1][c], in_win[2][c]);
      end
   end

   // The median of nine is the median of the largest column minimum, the middle
   // of the column middles and the smallest column maximum.
   always_comb begin
      trio_type s_lo;
      trio_type s_mid;
      trio_type s_hi;
      s_lo        = sort3(col_ff[0].lo, col_ff[1].lo, col_ff[2].lo);
      s_mid       = sort3(col_ff[0].mid, col_ff[1].mid, col_ff[2].mid);
      s_hi        = sort3(col_ff[0].hi, col_ff[1].hi, col_ff[2].hi);
      comb_in.lo  = s_lo.hi;
      comb_in.mid = s_mid.mid;
      comb_in.hi  = s_hi.lo;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_a_ff <= '0;
         tag_b_ff <= '0;
      end else if (enable) begin
         tag_a_ff <= in_tag;
         tag_b_ff <= tag_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         col_ff  <= col_in;
         comb_ff <= comb_in;
      end
   end

   assign final_sort = sort3(comb_ff.lo, comb_ff.mid, comb_ff.hi);
   assign out_pixel  = final_sort.mid;
   assign out_tag    = tag_b_ff;

endmodule

>>> rtl/core/median_filter_3x3.sv
// Top level of the 3x3 median filter: position counters, line store, window
// and output register. Depends on mf3_pkg, mf3_ram and mf3_median.
`timescale 1ns / 1ps

// Channel  Direction  Handshake              Payload
// req      in         req_valid / req_stall  req_data  (req_type, in_pixel)
// rsp      out        rsp_valid / rsp_stall  rsp_data  (out_pixel, frame_last)
// csr      in         csr_we                 csr_index, csr_wdata
//
// One transaction per cycle is accepted while req_stall is low; the line store is
// read and written once per cycle; its registered read sets the first pipeline
// stage. A result is offered on rsp once the transaction that causes it has passed
// the line store read, window, column sort and combine stages and the output register.
// Reset is synchronous; the line store needs no clearing, as rows not yet written
// are masked. rsp_stall holds the pipeline only while a result waits in the
// output register and another has reached the end of the median network.

module median_filter_3x3
   import mf3_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [11:0]  csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = 13;
   localparam int WCAP  = (MAX_WIDTH < 4095) ? MAX_WIDTH : 4095;

   logic [11:0]      frame_width_ff;
   logic [11:0]      frame_height_ff;
   logic [11:0]      width_eff;
   logic [11:0]      height_eff;

   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;

   logic             enable;
   logic             in_frame;
   logic             take;
   logic             s0_emit;
   logic             s0_last;
   logic             col_wrap;

   logic             p1_valid_ff;
   logic [COL_W-1:0] p1_col_ff;
   pixel_type        p1_pix_ff;
   logic             p1_hi_ok_ff;
   logic             p1_lo_ok_ff;
   logic             p1_emit_ff;
   logic             p1_last_ff;
   logic             p1_col0_ff;
   logic             p1_col1_ff;

   logic [15:0]      line_rd;
   pixel_type        hi_pix;
   pixel_type        lo_pix;
   logic             line_wr;

   window_type       win_ff;
   tag_type          p2_tag_ff;
   logic             p2_col0_ff;
   logic             p2_col1_ff;
   window_type       win_masked;

   tag_type          med_tag;
   pixel_type        med_pixel;

   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_item_type     rsp_data_ff;

   // Effective frame size after clamping.
   always_comb begin
      if (frame_width_ff < MIN_WIDTH) begin
         width_eff = MIN_WIDTH;
      end else if (32'(frame_width_ff) > WCAP) begin
         width_eff = 12'(WCAP);
      end else begin
         width_eff = frame_width_ff;
      end
      height_eff = (frame_height_ff == 12'd0) ? 12'd1 : frame_height_ff;
   end

   assign enable    = !(rsp_valid_ff && rsp_stall && med_tag.valid);
   assign req_stall = !enable;

   // A flush transaction before the frame's last pixel is swallowed without effect.
   assign in_frame = row_ff < ROW_W'(height_eff);
   assign take     = req_valid && enable && !(in_frame && req_data.req_type == REQ_FLUSH);
   assign s0_emit  = (row_ff >= ROW_W'(2)) || (row_ff == ROW_W'(1) && col_ff != '0);
   assign s0_last  = (row_ff == ROW_W'(height_eff) + ROW_W'(1)) && (col_ff == '0);
   assign col_wrap = (32'(col_ff) + 32'd1) == 32'(width_eff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (csr_we) begin
         col_in = '0;
         row_in = '0;
      end else if (take) begin
         if (s0_emit && s0_last) begin
            col_in = '0;
            row_in = '0;
         end else if (col_wrap) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         if (csr_we) begin
            case (csr_index)
               REG_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
               REG_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Stage 1: line store read is in flight.
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else if (enable) begin
         p1_valid_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p1_col_ff   <= col_ff;
         p1_pix_ff   <= in_frame ? req_data.in_pixel : '0;
         p1_hi_ok_ff <= row_ff >= ROW_W'(2);
         p1_lo_ok_ff <= (row_ff != '0) && (row_ff <= ROW_W'(height_eff));
         p1_emit_ff  <= s0_emit;
         p1_last_ff  <= s0_last;
         p1_col0_ff  <= col_ff == '0;
         p1_col1_ff  <= col_ff == COL_W'(1);
      end
   end

   // Each entry holds the two previous rows of its column, the older in the high byte.
   mf3_ram #(
      .WIDTH(16),
      .DEPTH(MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (line_wr),
      .wr_addr (p1_col_ff),
      .wr_data ({lo_pix, p1_pix_ff}),
      .rd_en   (take),
      .rd_addr (col_ff),
      .rd_data (line_rd)
   );

   assign hi_pix  = p1_hi_ok_ff ? line_rd[15:8] : '0;
   assign lo_pix  = p1_lo_ok_ff ? line_rd[7:0] : '0;
   assign line_wr = p1_valid_ff && enable;

   // Stage 2: the window shifts in the new column.
   always_ff @(posedge clock) begin
      if (line_wr) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= win_ff[r][1];
            win_ff[r][1] <= win_ff[r][2];
         end
         win_ff[0][2] <= hi_pix;
         win_ff[1][2] <= lo_pix;
         win_ff[2][2] <= p1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_tag_ff <= '0;
      end else if (enable) begin
         p2_tag_ff.valid <= p1_valid_ff && p1_emit_ff;
         p2_tag_ff.last  <= p1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p2_col0_ff <= p1_col0_ff;
         p2_col1_ff <= p1_col1_ff;
      end
   end

   // At the start of a row the newest column belongs to the next row, and one
   // step later the oldest column belongs to the previous row: both lie outside.
   always_comb begin
      win_masked = win_ff;
      for (int r = 0; r < 3; r++) begin
         if (p2_col0_ff) begin
            win_masked[r][2] = '0;
         end
         if (p2_col1_ff) begin
            win_masked[r][0] = '0;
         end
      end
   end

   mf3_median u_median (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_tag    (p2_tag_ff),
      .in_win    (win_masked),
      .out_tag   (med_tag),
      .out_pixel (med_pixel)
   );

   // Output register.
   always_comb begin
      if (enable) begin
         rsp_valid_in = med_tag.valid || (rsp_valid_ff && rsp_stall);
      end else begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable && med_tag.valid) begin
         rsp_data_ff.out_pixel  <= med_pixel;
         rsp_data_ff.frame_last <= med_tag.last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
